// ===== design/dcbc_pkg.sv =====
// Package for the DES CBC block cipher unit.
// Holds the DES permutation tables, S-boxes, key schedule and round functions.
// No dependencies.
package dcbc_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CIPHER_KEY   = 2'd0,
    REG_INIT_VECTOR  = 2'd1,
    REG_DECRYPT_MODE = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef logic [47:0] subkey_t;
  typedef subkey_t [15:0] subkeys_t;

  localparam logic [6:0] TabIp [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

  localparam logic [6:0] TabFp [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

  localparam logic [5:0] TabE [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1 };

  localparam logic [5:0] TabP [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

  localparam logic [6:0] TabPc1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };

  localparam logic [5:0] TabPc2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32 };

  localparam logic [1:0] KeyRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam logic [3:0] Sbox [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // Table entries number bits from the MSB, starting at 1.
  function automatic logic [63:0] perm_ip(logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-TabIp[i]];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-TabFp[i]];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-TabPc1[i]];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-TabPc2[i]];
    return r;
  endfunction

  function automatic logic [27:0] rot28(logic [27:0] v, logic [1:0] s);
    return (s == 2'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
  endfunction

  function automatic subkeys_t key_schedule(logic [63:0] key);
    subkeys_t sub;
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    cd = perm_pc1(key);
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < 16; i++) begin
      c = rot28(c, KeyRot[i]);
      d = rot28(d, KeyRot[i]);
      sub[i] = perm_pc2({c, d});
    end
    return sub;
  endfunction

  function automatic logic [31:0] feistel(logic [31:0] r, logic [47:0] k);
    logic [47:0] x;
    logic [31:0] o;
    logic [31:0] p;
    logic [5:0] b;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-TabE[i]];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      o[31-4*i -: 4] = Sbox[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[32-TabP[i]];
    return p;
  endfunction

endpackage

// ===== design/dcbc_if.sv =====
// Valid/ready stream interface for the DES CBC unit channels.
// Payload type set per instance; uses no package.
interface dcbc_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/dcbc_cfg_regs.sv =====
// Configuration register file: key, IV and direction.
// Depends on dcbc_pkg.
module dcbc_cfg_regs
  import dcbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [63:0]         wr_data,
  output logic [63:0]         cipher_key,
  output logic [63:0]         init_vector,
  output logic                decrypt_mode
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key   <= '0;
      init_vector  <= '0;
      decrypt_mode <= DIR_ENCRYPT;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_CIPHER_KEY:   cipher_key   <= wr_data;
        REG_INIT_VECTOR:  init_vector  <= wr_data;
        REG_DECRYPT_MODE: decrypt_mode <= wr_data[0];
        default: ;
      endcase
    end
  end
endmodule

// ===== design/dcbc_core.sv =====
// Unrolled 16-round DES with key schedule; pure combinational datapath.
// Depends on dcbc_pkg.
module dcbc_core
  import dcbc_pkg::*;
(
  input  logic [63:0] blk,
  input  logic [63:0] key,
  input  logic        dec,
  output logic [63:0] result
);
  subkeys_t    sub;
  logic [63:0] v;
  logic [31:0] l [17];
  logic [31:0] r [17];

  assign sub = key_schedule(key);
  assign v = perm_ip(blk);
  assign l[0] = v[63:32];
  assign r[0] = v[31:0];

  for (genvar i = 0; i < 16; i++) begin : g_round
    logic [47:0] k;
    assign k = dec ? sub[15-i] : sub[i];
    assign l[i+1] = r[i];
    assign r[i+1] = l[i] ^ feistel(r[i], k);
  end

  assign result = perm_fp({r[16], l[16]});
endmodule

// ===== design/des_cbc_block_cipher_unit.sv =====
// DES CBC block cipher unit, top level.
// Depends on dcbc_pkg, dcbc_if, dcbc_cfg_regs and dcbc_core.
//
// Channels: "in" carries block_in and start_of_message, "out" carries
// block_out, "cfg" writes register index/data (0 key, 1 IV, 2 direction).
// cfg is always ready. A transfer on "in" is chained with the chaining
// register (before the 16 combinational DES rounds when encrypting, after
// them when decrypting); the result appears in the output register on the
// next cycle. Throughput is one block per cycle unless the receiver stalls;
// the encrypt chain feedback through all 16 rounds sets the clock period.
// "in" is ready whenever the output register is empty or being drained,
// so a stalled receiver holds the result and back-pressures the input.
// Reset clears key, IV, direction, chaining value and output valid.
// start_of_message reloads the chaining value from the IV for that block.
module des_cbc_block_cipher_unit
  import dcbc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  dcbc_if.sink   in,
  dcbc_if.source out,
  dcbc_if.sink   cfg
);
  logic [63:0] cipher_key;
  logic [63:0] init_vector;
  logic        decrypt_mode;
  logic [63:0] chain_value;
  logic [63:0] chain_value_next;
  logic [63:0] chain_sel;
  logic [63:0] core_in;
  logic [63:0] core_out;
  logic [63:0] result_next;
  logic [63:0] block_out;
  logic        out_valid;
  logic        take;

  assign cfg.ready = 1'b1;

  dcbc_cfg_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (cfg.valid),
    .wr_index     (cfg.data.index),
    .wr_data      (cfg.data.value),
    .cipher_key   (cipher_key),
    .init_vector  (init_vector),
    .decrypt_mode (decrypt_mode)
  );

  assign in.ready = !out_valid || out.ready;
  assign take = in.valid && in.ready;

  assign chain_sel = in.data.start_of_message ? init_vector : chain_value;
  assign core_in = (decrypt_mode == DIR_DECRYPT) ? in.data.block_in
                                                 : (in.data.block_in ^ chain_sel);

  dcbc_core u_core (
    .blk    (core_in),
    .key    (cipher_key),
    .dec    (decrypt_mode),
    .result (core_out)
  );

  always_comb begin
    if (decrypt_mode == DIR_DECRYPT) begin
      result_next      = core_out ^ chain_sel;
      chain_value_next = in.data.block_in;
    end else begin
      result_next      = core_out;
      chain_value_next = core_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_value <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take) chain_value <= chain_value_next;
      if (take) out_valid <= 1'b1;
      else if (out.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) block_out <= result_next;
  end

  assign out.valid = out_valid;
  assign out.data.block_out = block_out;
endmodule

// ===== design/dcbc_checker.sv =====
// Port-level checker for the DES CBC unit, bound to the top level.
// Depends on dcbc_if only through the bound top-level ports.
module dcbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted block gave no result");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input not ready while output free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind des_cbc_block_cipher_unit dcbc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in.valid),
  .in_ready  (in.ready),
  .out_valid (out.valid),
  .out_ready (out.ready),
  .out_data  (out.data.block_out)
);
